>>> rtl/bfuh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter hash unit package
// Field widths, action and register codes, the Mersenne prime and the
// sequencer state type shared by the filter and its checker.
// ----------------------------------------------------------------------------
package bfuh_pkg;

	// Field widths of the command and configuration ports.
	localparam int ACT_W   = 2;
	localparam int KEY_W   = 32;
	localparam int CIDX_W  = 4;
	localparam int COEF_W  = 61;
	localparam int TS_W    = 17;
	localparam int HC_W    = 5;
	localparam int CFG_W   = 17;
	localparam int CFG_IDX_W = 2;

	// The Mersenne prime 2^61 - 1.
	localparam logic [COEF_W-1:0] PRIME_M61 = {COEF_W{1'b1}};

	// Remainder unit: dividend padded to whole digits, four bits per cycle.
	localparam int DIV_IN_W     = 64;
	localparam int DIV_STEP     = 4;
	localparam int DIV_CYCLES   = DIV_IN_W / DIV_STEP;
	localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

	// Command actions.
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT = 2'd1;

	// Sequencer states, one-hot.
	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_CLEAR = 11'b000_0000_0010,
		ST_RD    = 11'b000_0000_0100,
		ST_MUL0  = 11'b000_0000_1000,
		ST_MUL1  = 11'b000_0001_0000,
		ST_SUM   = 11'b000_0010_0000,
		ST_ADD   = 11'b000_0100_0000,
		ST_FOLD  = 11'b000_1000_0000,
		ST_DIV   = 11'b001_0000_0000,
		ST_TBL   = 11'b010_0000_0000,
		ST_CHK   = 11'b100_0000_0000
	} state_t;

endpackage

>>> rtl/bfuh_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter hash remainder unit
// Restoring remainder of a 61-bit hash value by the table size, four
// dividend bits per cycle.
// ----------------------------------------------------------------------------
module bfuh_mod_unit
	import bfuh_pkg::*;
#(
	parameter int N_W = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [COEF_W-1:0] dividend,
	input  logic [N_W-1:0]    divisor,
	output logic              done,
	output logic [N_W-1:0]    rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_IN_W-1:0]  sh_q;
	logic [N_W-1:0]       rem_q;
	logic [DIV_IN_W-1:0]  sh_next;
	logic [N_W-1:0]       rem_next;

	// Four restoring steps: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		logic [N_W:0] trial;
		sh_next  = sh_q;
		rem_next = rem_q;
		for (int j = 0; j < DIV_STEP; j++) begin
			trial   = {rem_next, sh_next[DIV_IN_W-1]};
			sh_next = {sh_next[DIV_IN_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_next = N_W'(trial - {1'b0, divisor});
			end else begin
				rem_next = N_W'(trial);
			end
		end
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shift register and partial remainder.
	always_ff @(posedge clk) begin
		if (go) begin
			sh_q  <= {{(DIV_IN_W-COEF_W){1'b0}}, dividend};
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_next;
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> rtl/bloom_filter_universal_hash_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter with universal hashing
// Bit table filter; hash i is ((a_i * key + b_i) mod (2^61 - 1)) mod size.
// ----------------------------------------------------------------------------
// Usage:
// A command is taken at a rising edge where start is high and busy is low.
// Action insert sets the bits of all hashes of key, query tests them, and
// load writes one coefficient pair in a single cycle without raising busy.
// Only a query gives a result: present is valid for exactly one cycle while
// done is high, and the receiver cannot hold it off.
// Each hash runs through the coefficient read, two 32 x 32 partial products,
// two additions, the Mersenne fold, the four-bit-per-cycle remainder unit
// and the bit table access and check. An insert or query keeps busy high
// while its hashes run one after another, and done is shown in the first
// cycle after busy falls, in which a new command may already be taken.
// After reset the bit table is swept clear, one entry per cycle, with busy
// high. Configuration writes are always taken (cfg_ready is high) and must
// be made only while no command is in work.
// ----------------------------------------------------------------------------
module bloom_filter_universal_hash_unit
	import bfuh_pkg::*;
#(
	parameter int TABLE_BITS = 65536,
	parameter int MAX_HASHES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [ACT_W-1:0]     action,
	input  logic [KEY_W-1:0]     key,
	input  logic [CIDX_W-1:0]    coeff_index,
	input  logic [COEF_W-1:0]    coeff_mult,
	input  logic [COEF_W-1:0]    coeff_add,
	output logic                 done,
	output logic                 present,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int ADDR_W = $clog2(TABLE_BITS);
	localparam int N_W    = ADDR_W + 1;
	localparam int HIDX_W = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
	localparam int K_W    = $clog2(MAX_HASHES + 1);

	state_t              state_q;
	logic [K_W-1:0]      cnt_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [TS_W-1:0]     table_size_q;
	logic [HC_W-1:0]     hash_count_q;
	logic [N_W-1:0]      n_q;
	logic [K_W-1:0]      k_q;
	logic                all_q;
	logic                done_q;
	logic                present_q;
	logic [ACT_W-1:0]    act_q;
	logic [KEY_W-1:0]    key_q;
	logic [COEF_W-1:0]   a_q;
	logic [COEF_W-1:0]   b_q;
	logic [63:0]         p0_q;
	logic [COEF_W-1:0]   p1_q;
	logic [COEF_W:0]     x_q;
	logic [COEF_W:0]     y_q;
	logic [COEF_W+1:0]   s_q;
	logic                bit_rd_q;

	logic [2*COEF_W-1:0] coef_mem [MAX_HASHES];
	logic                bit_mem [TABLE_BITS];

	logic                accept;
	logic                coef_we;
	logic [N_W-1:0]      n_use;
	logic [K_W-1:0]      k_use;
	logic                last_hash;
	logic [31:0]         mul_op;
	logic [63:0]         prod;
	logic [COEF_W:0]     fold;
	logic [COEF_W-1:0]   hash_val;
	logic                mod_go;
	logic                mod_done;
	logic [N_W-1:0]      mod_rem;
	logic                tbl_we;
	logic [ADDR_W-1:0]   tbl_addr;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign coef_we   = accept && (action == ACT_LOAD) && (32'(coeff_index) < MAX_HASHES);
	assign last_hash = (K_W'(cnt_q + K_W'(1)) == k_q);

	// Table size and hash count limited to the range the hardware holds.
	always_comb begin
		if (table_size_q == '0) begin
			n_use = N_W'(1);
		end else if (32'(table_size_q) > TABLE_BITS) begin
			n_use = N_W'(TABLE_BITS);
		end else begin
			n_use = N_W'(table_size_q);
		end
		if (hash_count_q == '0) begin
			k_use = K_W'(1);
		end else if (32'(hash_count_q) > MAX_HASHES) begin
			k_use = K_W'(MAX_HASHES);
		end else begin
			k_use = K_W'(hash_count_q);
		end
	end

	// One shared 32 x 32 multiplier for the low and high coefficient halves.
	assign mul_op = (state_q == ST_MUL0) ? a_q[31:0] : {3'b000, a_q[COEF_W-1:32]};
	assign prod   = {32'b0, mul_op} * {32'b0, key_q};

	// Final fold by 2^61 = 1 and one conditional subtraction of the prime.
	assign fold     = {1'b0, s_q[COEF_W-1:0]} + (COEF_W+1)'(s_q[COEF_W+1:COEF_W]);
	assign hash_val = (fold >= {1'b0, PRIME_M61}) ? COEF_W'(fold - {1'b0, PRIME_M61})
	                                             : fold[COEF_W-1:0];
	assign mod_go   = (state_q == ST_FOLD);

	bfuh_mod_unit #(
		.N_W(N_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (mod_go),
		.dividend (hash_val),
		.divisor  (n_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TS_W'(65536);
			hash_count_q <= HC_W'(7);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TABLE_SIZE: table_size_q <= cfg_data[TS_W-1:0];
				CFG_HASH_COUNT: hash_count_q <= cfg_data[HC_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: clearing sweep after reset, then hashes one after another.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			clr_q     <= '0;
			all_q     <= 1'b1;
			done_q    <= 1'b0;
			present_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (action == ACT_INSERT || action == ACT_QUERY)) begin
						cnt_q   <= '0;
						all_q   <= 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(TABLE_BITS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD:   state_q <= ST_MUL0;
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_FOLD;
				ST_FOLD: state_q <= ST_DIV;
				ST_DIV: begin
					if (mod_done) begin
						state_q <= ST_TBL;
					end
				end
				ST_TBL:  state_q <= ST_CHK;
				ST_CHK: begin
					if (act_q == ACT_QUERY && !bit_rd_q) begin
						all_q <= 1'b0;
					end
					if (last_hash) begin
						if (act_q == ACT_QUERY) begin
							done_q    <= 1'b1;
							present_q <= all_q & bit_rd_q;
						end
						state_q <= ST_IDLE;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command capture and the hash datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			key_q <= key;
			n_q   <= n_use;
			k_q   <= k_use;
		end
		if (state_q == ST_MUL0) begin
			p0_q <= prod;
		end
		if (state_q == ST_MUL1) begin
			p1_q <= prod[COEF_W-1:0];
		end
		if (state_q == ST_SUM) begin
			x_q <= {1'b0, p0_q[COEF_W-1:0]} + {1'b0, b_q};
			y_q <= {1'b0, p1_q[28:0], p1_q[COEF_W-1:29]} + (COEF_W+1)'(p0_q[63:COEF_W]);
		end
		if (state_q == ST_ADD) begin
			s_q <= {1'b0, x_q} + {1'b0, y_q};
		end
	end

	// Coefficient memory: a pair written by a load, read at the current hash index.
	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[HIDX_W'(coeff_index)] <= {coeff_mult, coeff_add};
		end
		{a_q, b_q} <= coef_mem[cnt_q[HIDX_W-1:0]];
	end

	// Bit table: cleared by the sweep, set by inserts, read by queries.
	assign tbl_we   = (state_q == ST_CLEAR) || (state_q == ST_TBL && act_q == ACT_INSERT);
	assign tbl_addr = (state_q == ST_CLEAR) ? clr_q : mod_rem[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			bit_mem[tbl_addr] <= (state_q != ST_CLEAR);
		end
		bit_rd_q <= bit_mem[tbl_addr];
	end

	assign done    = done_q;
	assign present = present_q;

endmodule

>>> rtl/bfuh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter hash unit checker
// Port-level checks of the command sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module bfuh_checker
	import bfuh_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [ACT_W-1:0] action
);

	// A result only follows a command that kept the unit busy.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe without a preceding busy period");

	// Result strobes never come back to back.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// An accepted insert or query occupies the unit.
	a_work_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_INSERT || action == ACT_QUERY)) |=> busy)
		else $error("insert or query transaction did not raise busy");

	// A load completes in its own cycle and gives no result.
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_LOAD) |=> (!busy && !done))
		else $error("load transaction raised busy or gave a result");

endmodule

bind bloom_filter_universal_hash_unit bfuh_checker u_bfuh_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.action (action)
);

>>> bench/bloom_filter_universal_hash_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter universal hash unit testbench
// Drives insert, query, coefficient load and unused commands into the filter
// and keeps its own model of the bit table and the coefficient pairs. Every
// query answer is checked against the model. Table size and hash count move
// through their extremes, and commands are sent after random idle gaps.
// ----------------------------------------------------------------------------
module bloom_filter_universal_hash_unit_test
	import bfuh_pkg::*;
();

	localparam int TABLE_BITS = 65536;
	localparam int MAX_HASHES = 16;

	// A full command at the largest hash count is over within this.
	localparam int SETTLE_CYCLES = 25 * MAX_HASHES + 16;
	// The sweep of the bit table after reset is the longest quiet stretch.
	localparam int WATCHDOG_LIMIT = 4 * TABLE_BITS;
	localparam int KEY_POOL_DEPTH = 128;

	// Action code that the filter ignores.
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
	// Register indexes with no register behind them.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	typedef struct {
		logic [ACT_W-1:0]  act;
		logic [KEY_W-1:0]  key;
		logic [CIDX_W-1:0] idx;
		logic [COEF_W-1:0] mult;
		logic [COEF_W-1:0] add;
	} command_t;

	typedef struct {
		logic [KEY_W-1:0] key;
		logic             present;
	} query_answer_t;

	typedef struct {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
	} reg_write_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [ACT_W-1:0]     action = '0;
	logic [KEY_W-1:0]     key = '0;
	logic [CIDX_W-1:0]    coeff_index = '0;
	logic [COEF_W-1:0]    coeff_mult = '0;
	logic [COEF_W-1:0]    coeff_add = '0;
	logic                 done;
	logic                 present;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Model of the filter state and its registers.
	bit               slot_mirror [TABLE_BITS];
	bit [COEF_W-1:0]  mult_mirror [MAX_HASHES];
	bit [COEF_W-1:0]  add_mirror [MAX_HASHES];
	bit [TS_W-1:0]    size_reg = TS_W'(65536);
	bit [HC_W-1:0]    count_reg = HC_W'(7);

	query_answer_t    expected_answers[$];
	logic [KEY_W-1:0] inserted_keys[$];
	reg_write_t       pending_writes[$];

	int unsigned fail_count = 0;
	int unsigned answers_checked = 0;
	int unsigned inserts_sent = 0;
	int unsigned queries_sent = 0;
	int unsigned present_hits = 0;
	int unsigned loads_sent = 0;
	int unsigned spare_sent = 0;
	int unsigned reg_writes = 0;
	int unsigned settings_used = 0;
	int unsigned stall_cycles = 0;

	bloom_filter_universal_hash_unit #(
		.TABLE_BITS(TABLE_BITS),
		.MAX_HASHES(MAX_HASHES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.key(key),
		.coeff_index(coeff_index),
		.coeff_mult(coeff_mult),
		.coeff_add(coeff_add),
		.done(done),
		.present(present),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock generation.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Table size in force: zero acts as one, oversize values are clipped.
	function automatic int unsigned active_size();
		if (size_reg == 0)
			return 1;
		if (size_reg > TABLE_BITS)
			return TABLE_BITS;
		return 32'(size_reg);
	endfunction

	function automatic int unsigned active_hashes();
		if (count_reg == 0)
			return 1;
		if (count_reg > MAX_HASHES)
			return MAX_HASHES;
		return 32'(count_reg);
	endfunction

	// Bit table index of hash h for key k, with the product taken exactly.
	function automatic int unsigned hash_slot(int unsigned h, logic [KEY_W-1:0] k);
		bit [127:0] acc;
		acc = 128'(mult_mirror[h]) * 128'(k) + 128'(add_mirror[h]);
		acc = acc % 128'(PRIME_M61);
		acc = acc % 128'(active_size());
		return acc[31:0];
	endfunction

	// Apply one accepted command to the model and queue any answer it owes.
	function automatic void predict_command(command_t c);
		query_answer_t ans;
		int unsigned   slot;
		case (c.act)
			ACT_LOAD: begin
				mult_mirror[c.idx] = c.mult;
				add_mirror[c.idx] = c.add;
				loads_sent++;
			end
			ACT_INSERT: begin
				for (int h = 0; h < active_hashes(); h++) begin
					slot = hash_slot(h, c.key);
					slot_mirror[slot] = 1'b1;
				end
				inserted_keys = {inserted_keys, c.key};
				if (inserted_keys.size() > KEY_POOL_DEPTH)
					void'(inserted_keys.pop_front());
				inserts_sent++;
			end
			ACT_QUERY: begin
				ans.key = c.key;
				ans.present = 1'b1;
				for (int h = 0; h < active_hashes(); h++) begin
					slot = hash_slot(h, c.key);
					if (!slot_mirror[slot])
						ans.present = 1'b0;
				end
				if (ans.present)
					present_hits++;
				expected_answers = {expected_answers, ans};
				queries_sent++;
			end
			default: begin
				spare_sent++;
			end
		endcase
	endfunction

	function automatic void predict_register_write(reg_write_t w);
		case (w.index)
			CFG_TABLE_SIZE: size_reg = w.data[TS_W-1:0];
			CFG_HASH_COUNT: count_reg = w.data[HC_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endfunction

	// ------------------------------------------------------------------------
	// Random values
	// ------------------------------------------------------------------------

	// Idle time before a command: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 4);
		if (roll < 96)
			return $urandom_range(5, 40);
		return $urandom_range(100, 450);
	endfunction

	// Coefficient in the full 61-bit range, the prime itself included.
	function automatic logic [COEF_W-1:0] pick_coeff();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 4)
			return '0;
		if (roll < 8)
			return PRIME_M61;
		if (roll < 12)
			return PRIME_M61 - 1;
		return COEF_W'({$urandom, $urandom});
	endfunction

	// Key: extremes, a key inserted earlier, or a fresh random one.
	function automatic logic [KEY_W-1:0] pick_key(int unsigned reuse_pct);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 6) begin
			case ($urandom_range(3))
				0: return '0;
				1: return '1;
				2: return 32'h8000_0000;
				default: return 32'h0000_0001;
			endcase
		end
		if (roll < 6 + reuse_pct && inserted_keys.size() != 0)
			return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
		return $urandom;
	endfunction

	// Command with random content in the fields that its action ignores.
	function automatic command_t make_command(logic [ACT_W-1:0] act,
			logic [KEY_W-1:0] k);
		command_t c;
		c.act = act;
		c.key = k;
		c.idx = CIDX_W'($urandom);
		c.mult = COEF_W'({$urandom, $urandom});
		c.add = COEF_W'({$urandom, $urandom});
		return c;
	endfunction

	function automatic command_t make_load(int unsigned idx, logic [COEF_W-1:0] a,
			logic [COEF_W-1:0] b);
		command_t c;
		c = make_command(ACT_LOAD, $urandom);
		c.idx = CIDX_W'(idx);
		c.mult = a;
		c.add = b;
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// Shared driving tasks
	// ------------------------------------------------------------------------

	// Idle for the given gap, then hold the command until it is accepted.
	// Start is left high so that the next command can follow directly.
	task automatic send_command(input command_t c, input int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= c.act;
		key <= c.key;
		coeff_index <= c.idx;
		coeff_mult <= c.mult;
		coeff_add <= c.add;
		do
			@(posedge clk);
		while (busy);
		predict_command(c);
	endtask

	// Hold off new commands until every outstanding answer has arrived.
	task automatic wait_for_answers();
		start <= 1'b0;
		do
			@(posedge clk);
		while (expected_answers.size() != 0);
	endtask

	// Let the filter go fully idle, including an insert still in work.
	task automatic drain_and_settle();
		wait_for_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Perform the queued register writes as one burst of transactions.
	task automatic program_registers();
		reg_write_t w;
		while (pending_writes.size() != 0) begin
			w = pending_writes.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.index;
			cfg_data <= w.data;
			do
				@(posedge clk);
			while (!cfg_ready);
			predict_register_write(w);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		reg_write_t w;
		w.index = idx;
		w.data = data;
		pending_writes = {pending_writes, w};
	endtask

	// Idle the block, then set table size and hash count.
	task automatic apply_settings(input logic [CFG_W-1:0] size_data,
			input logic [CFG_W-1:0] count_data);
		drain_and_settle();
		queue_write(CFG_TABLE_SIZE, size_data);
		queue_write(CFG_HASH_COUNT, count_data);
		program_registers();
		settings_used++;
	endtask

	// Random mix dominated by inserts and queries, often of known keys.
	task automatic run_traffic(input int unsigned count, input bit allow_gaps);
		int unsigned issued;
		int unsigned roll;
		int unsigned gap;
		command_t    c;
		issued = 0;
		while (issued < count) begin
			roll = $urandom_range(99);
			if (roll < 6)
				c = make_load($urandom_range(MAX_HASHES - 1), pick_coeff(), pick_coeff());
			else if (roll < 40)
				c = make_command(ACT_INSERT, pick_key(30));
			else if (roll < 95)
				c = make_command(ACT_QUERY, pick_key(55));
			else
				c = make_command(ACT_SPARE, $urandom);
			gap = allow_gaps ? pick_gap() : 0;
			if (allow_gaps && $urandom_range(199) == 0) begin
				wait_for_answers();
				gap = 0;
			end
			send_command(c, gap);
			if (c.act != ACT_SPARE)
				issued++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------------

	// Load every coefficient pair, extremes first, then basic commands at the
	// reset values of the registers.
	task automatic test_directed_commands();
		send_command(make_load(0, PRIME_M61, PRIME_M61), 0);
		send_command(make_load(1, '0, PRIME_M61 - 1), 0);
		send_command(make_load(2, PRIME_M61 - 1, '0), 1);
		send_command(make_load(3, COEF_W'(1), COEF_W'(1)), 0);
		for (int h = 4; h < MAX_HASHES; h++)
			send_command(make_load(h, COEF_W'({$urandom, $urandom}),
				COEF_W'({$urandom, $urandom})), 0);
		send_command(make_command(ACT_QUERY, '0), 0);
		send_command(make_command(ACT_INSERT, '0), 2);
		send_command(make_command(ACT_QUERY, '0), 0);
		send_command(make_command(ACT_QUERY, '1), 0);
		send_command(make_command(ACT_INSERT, '1), 0);
		send_command(make_command(ACT_SPARE, 32'h1234_5678), 3);
		send_command(make_command(ACT_QUERY, '1), 0);
		send_command(make_command(ACT_QUERY, 32'h8000_0000), 0);
	endtask

	// Each register at its bounds and beyond, and writes to unused indexes.
	task automatic test_register_extremes();
		apply_settings(CFG_W'(0), CFG_W'(1));
		run_traffic(40, 1'b1);
		apply_settings(CFG_W'(1), CFG_W'(16));
		run_traffic(40, 1'b0);
		apply_settings(CFG_W'(65536), CFG_W'(1));
		run_traffic(40, 1'b1);
		apply_settings(CFG_W'(131071), CFG_W'(0));
		run_traffic(40, 1'b1);
		apply_settings(CFG_W'(65537), CFG_W'(31));
		run_traffic(40, 1'b0);
		// Upper data bits are outside the hash count register.
		apply_settings(CFG_W'(97), {12'hFFF, 5'd3});
		run_traffic(40, 1'b1);
		apply_settings(CFG_W'(4096), CFG_W'(5));
		drain_and_settle();
		queue_write(CFG_SPARE_LO, '1);
		queue_write(CFG_SPARE_HI, CFG_W'($urandom));
		queue_write(CFG_SPARE_LO, '0);
		program_registers();
		run_traffic(40, 1'b1);
	endtask

	// Random register settings, mostly small tables and few hashes.
	task automatic test_random_traffic();
		int unsigned size_pick;
		int unsigned count_pick;
		for (int phase = 0; phase < 8; phase++) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: size_pick = $urandom_range(1, 256);
				5, 6, 7: size_pick = $urandom_range(257, 8192);
				default: size_pick = $urandom_range(8193, TABLE_BITS);
			endcase
			count_pick = ($urandom_range(9) < 7) ? $urandom_range(1, 8)
				: $urandom_range(9, MAX_HASHES);
			apply_settings(CFG_W'(size_pick),
				{CFG_W'($urandom) & ~CFG_W'(5'h1F)} | CFG_W'(count_pick));
			run_traffic(40, phase % 3 != 2);
		end
	endtask

	// ------------------------------------------------------------------------
	// Answer checking
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		query_answer_t oldest;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				$error("present: no query outstanding, got %0b", present);
				fail_count++;
			end else begin
				oldest = expected_answers.pop_front();
				answers_checked++;
				if (present !== oldest.present) begin
					$error("present: expected %0b, actual %0b (key %h)",
						oldest.present, present, oldest.key);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: cycles since the last transaction on any port
	// ------------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_cycles <= 0;
		else if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		do
			@(posedge clk);
		while (stall_cycles < WATCHDOG_LIMIT);
		$display("Watchdog expired after %0d quiet cycles", stall_cycles);
		$display("bloom_filter_universal_hash_unit_test failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_commands();
		test_register_extremes();
		test_random_traffic();
		drain_and_settle();
		$display("Covered %0d inserts, %0d queries (%0d present), %0d loads, %0d ignored",
			inserts_sent, queries_sent, present_hits, loads_sent, spare_sent);
		$display("Checked %0d answers over %0d register settings, %0d register writes",
			answers_checked, settings_used, reg_writes);
		if (fail_count == 0)
			$display("bloom_filter_universal_hash_unit_test passed");
		else
			$display("bloom_filter_universal_hash_unit_test failed");
		$finish;
	end

endmodule
